// ----- design/pbsd_pkg.sv -----
// Shared types, codes and sizes for the PackBits scanline decoder.
`default_nettype none

package pbsd_pkg;

  localparam int MAX_LINES_DEF = 16384;
  localparam int QUEUE_DEPTH   = 4;
  localparam int LIMIT_W       = 29;
  localparam int LINES_W       = 15;
  localparam int CFG_IDX_W     = 1;

  localparam logic [LIMIT_W-1:0] OUT_LIMIT_RST      = LIMIT_W'(1);
  localparam logic [LINES_W-1:0] SCANLINE_COUNT_RST = LINES_W'(1);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_OUT_LIMIT      = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SCANLINE_COUNT = 1'b1;

  localparam logic [7:0] HDR_NOP = 8'd128;

  typedef enum logic [1:0] {
    MODE_HEADER  = 2'd0,
    MODE_LITERAL = 2'd1,
    MODE_REPEAT  = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    ST_RUN        = 3'd0,
    ST_BAD_LEN    = 3'd1,
    ST_PAST_LINE  = 3'd2,
    ST_OVERFLOW   = 3'd3,
    ST_UNEXPECTED = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_LEN,
    ACT_LIT_BYTE,
    ACT_REP_BYTE,
    ACT_HDR_LIT,
    ACT_HDR_REP,
    ACT_FAIL
  } act_t;

  typedef struct packed {
    logic [7:0] run_value;
    logic [7:0] run_count;
    status_t    status;
  } run_rec_t;

endpackage

`default_nettype wire

// ----- design/pbsd_front.sv -----
// Front end: accepts items, keeps decode state, classifies beats and emits run records.
`default_nettype none

module pbsd_front import pbsd_pkg::*; #(
  parameter int MAX_LINES = MAX_LINES_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 accept,
  input  wire logic                 req_type,
  input  wire logic signed [15:0]   line_length,
  input  wire logic [7:0]           data_byte,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [LIMIT_W-1:0]   cfg_data,
  output logic                      rec_valid,
  output run_rec_t                  rec
);

  logic [LIMIT_W-1:0] out_limit_r;
  logic [LINES_W-1:0] scanline_count_r;

  mode_t              mode_r, mode_nxt;
  logic [7:0]         literal_left_r, literal_left_nxt;
  logic [7:0]         repeat_len_r, repeat_len_nxt;
  logic [14:0]        line_left_r, line_left_nxt;
  logic [LIMIT_W-1:0] written_r, written_nxt;
  logic [LINES_W-1:0] lines_r, lines_nxt;
  logic               failed_r, failed_nxt;

  act_t               act;
  status_t            fail_st;
  logic [14:0]        line_dec;
  logic [7:0]         hdr_cnt;
  logic [8:0]         rep_cnt9;
  logic [7:0]         lit_dec;
  logic               cap_hit;
  logic [LIMIT_W:0]   sum_w;

  assign line_dec = line_left_r - 15'd1;
  assign rep_cnt9 = 9'd257 - {1'b0, data_byte};
  assign hdr_cnt  = data_byte[7] ? rep_cnt9[7:0] : ({1'b0, data_byte[6:0]} + 8'd1);
  assign sum_w    = {1'b0, written_r} + (LIMIT_W+1)'(hdr_cnt);
  assign lit_dec  = (literal_left_r != 8'd0) ? literal_left_r - 8'd1 : 8'd0;
  assign cap_hit  = (lines_r >= scanline_count_r) || (32'(lines_r) >= 32'(MAX_LINES));

  // classify the beat
  always_comb begin
    act     = ACT_NONE;
    fail_st = ST_UNEXPECTED;
    if (!failed_r) begin
      if (!req_type) begin
        if (line_left_r != 15'd0 || cap_hit) begin
          act = ACT_FAIL;
        end else if (line_length == 16'sd0 || line_length[15]) begin
          act     = ACT_FAIL;
          fail_st = ST_BAD_LEN;
        end else begin
          act = ACT_LEN;
        end
      end else if (line_left_r == 15'd0) begin
        act = ACT_FAIL;
      end else if (mode_r == MODE_LITERAL) begin
        act = ACT_LIT_BYTE;
      end else if (mode_r == MODE_REPEAT) begin
        act = ACT_REP_BYTE;
      end else if (data_byte == HDR_NOP) begin
        act = ACT_NONE;
      end else if (!data_byte[7] && (15'(hdr_cnt) > line_dec)) begin
        act     = ACT_FAIL;
        fail_st = ST_PAST_LINE;
      end else if (data_byte[7] && line_dec == 15'd0) begin
        act     = ACT_FAIL;
        fail_st = ST_PAST_LINE;
      end else if (sum_w > {1'b0, out_limit_r}) begin
        act     = ACT_FAIL;
        fail_st = ST_OVERFLOW;
      end else begin
        act = data_byte[7] ? ACT_HDR_REP : ACT_HDR_LIT;
      end
    end
  end

  // next decode state
  always_comb begin
    mode_nxt         = mode_r;
    literal_left_nxt = literal_left_r;
    repeat_len_nxt   = repeat_len_r;
    line_left_nxt    = line_left_r;
    written_nxt      = written_r;
    lines_nxt        = lines_r;
    failed_nxt       = failed_r;
    if (accept) begin
      unique case (act)
        ACT_NONE: begin
          if (!failed_r) line_left_nxt = line_dec;
        end
        ACT_LEN: begin
          line_left_nxt = line_length[14:0];
          lines_nxt     = lines_r + LINES_W'(1);
          mode_nxt      = MODE_HEADER;
        end
        ACT_LIT_BYTE: begin
          line_left_nxt    = line_dec;
          literal_left_nxt = lit_dec;
          if (lit_dec == 8'd0) mode_nxt = MODE_HEADER;
        end
        ACT_REP_BYTE: begin
          line_left_nxt  = line_dec;
          mode_nxt       = MODE_HEADER;
          repeat_len_nxt = 8'd0;
        end
        ACT_HDR_LIT: begin
          line_left_nxt    = line_dec;
          written_nxt      = sum_w[LIMIT_W-1:0];
          mode_nxt         = MODE_LITERAL;
          literal_left_nxt = hdr_cnt;
        end
        ACT_HDR_REP: begin
          line_left_nxt  = line_dec;
          written_nxt    = sum_w[LIMIT_W-1:0];
          mode_nxt       = MODE_REPEAT;
          repeat_len_nxt = hdr_cnt;
        end
        ACT_FAIL: begin
          failed_nxt = 1'b1;
        end
        default: begin
          failed_nxt = failed_r;
        end
      endcase
    end
  end

  // result record
  always_comb begin
    rec_valid     = 1'b0;
    rec.run_value = 8'd0;
    rec.run_count = 8'd0;
    rec.status    = ST_RUN;
    if (accept) begin
      unique case (act)
        ACT_LIT_BYTE: begin
          rec_valid     = 1'b1;
          rec.run_value = data_byte;
          rec.run_count = 8'd1;
        end
        ACT_REP_BYTE: begin
          rec_valid     = 1'b1;
          rec.run_value = data_byte;
          rec.run_count = repeat_len_r;
        end
        ACT_FAIL: begin
          rec_valid  = 1'b1;
          rec.status = fail_st;
        end
        ACT_NONE, ACT_LEN, ACT_HDR_LIT, ACT_HDR_REP: begin
          rec_valid = 1'b0;
        end
        default: begin
          rec_valid = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_limit_r      <= OUT_LIMIT_RST;
      scanline_count_r <= SCANLINE_COUNT_RST;
      mode_r           <= MODE_HEADER;
      literal_left_r   <= 8'd0;
      repeat_len_r     <= 8'd0;
      line_left_r      <= 15'd0;
      written_r        <= '0;
      lines_r          <= '0;
      failed_r         <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_OUT_LIMIT)      out_limit_r      <= cfg_data;
        if (cfg_index == REG_SCANLINE_COUNT) scanline_count_r <= cfg_data[LINES_W-1:0];
      end
      mode_r         <= mode_nxt;
      literal_left_r <= literal_left_nxt;
      repeat_len_r   <= repeat_len_nxt;
      line_left_r    <= line_left_nxt;
      written_r      <= written_nxt;
      lines_r        <= lines_nxt;
      failed_r       <= failed_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- design/pbsd_queue.sv -----
// Back end: short result queue that holds run records until the consumer pops them.
`default_nettype none

module pbsd_queue import pbsd_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     wr_en,
  input  wire run_rec_t wr_rec,
  input  wire logic     pop,
  output logic          full,
  output logic          empty,
  output run_rec_t      head
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  run_rec_t         mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_pop;

  assign empty  = (count_r == CNT_W'(0));
  assign full   = (count_r == CNT_W'(QUEUE_DEPTH));
  assign do_pop = pop && !empty;
  assign head   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wr_ptr_r] <= wr_rec;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (wr_en)  wr_ptr_r <= (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      if (do_pop) rd_ptr_r <= (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      if (wr_en && !do_pop)      count_r <= count_r + CNT_W'(1);
      else if (!wr_en && do_pop) count_r <= count_r - CNT_W'(1);
    end
  end

endmodule

`default_nettype wire

// ----- design/packbits_scanline_decoder_unit.sv -----
// Top level of the PackBits scanline decoder: front decode stage and result queue.
// Throughput: one beat per cycle unless in_full; header, literal and length beats alike.
// Run and status records are registered into the result queue; out_ ports show its head.
// Stall: in_full rises once four results wait in the queue behind a stalled consumer.
// Reset (rst_n low at a clock edge) empties the queue, clears the decode state and error
// flag and sets out_limit and scanline_count back to 1.
`default_nettype none

module packbits_scanline_decoder_unit import pbsd_pkg::*; #(
  parameter int MAX_LINES = MAX_LINES_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // input queue side
  input  wire logic                 in_push,
  output logic                      in_full,
  input  wire logic                 in_req_type,
  input  wire logic signed [15:0]   in_line_length,
  input  wire logic [7:0]           in_data_byte,
  // result queue side
  output logic                      out_empty,
  input  wire logic                 out_pop,
  output logic [7:0]                out_run_value,
  output logic [7:0]                out_run_count,
  output logic [2:0]                out_status,
  // configuration write channel
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [LIMIT_W-1:0]   cfg_data
);

  logic     accept;
  logic     rec_valid;
  run_rec_t rec;
  run_rec_t head;

  // Accept a beat whenever the queue has a free slot; every beat makes at most one record.
  assign accept    = in_push && !in_full;
  // Registers are plain flops; take every write at once.
  assign cfg_ready = 1'b1;

  pbsd_front #(
    .MAX_LINES(MAX_LINES)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .req_type    (in_req_type),
    .line_length (in_line_length),
    .data_byte   (in_data_byte),
    .cfg_we      (cfg_valid && cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .rec_valid   (rec_valid),
    .rec         (rec)
  );

  // Queue finished records so a stalled consumer stops decode only once the queue is full.
  pbsd_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (rec_valid),
    .wr_rec (rec),
    .pop    (out_pop),
    .full   (in_full),
    .empty  (out_empty),
    .head   (head)
  );

  assign out_run_value = head.run_value;
  assign out_run_count = head.run_count;
  assign out_status    = head.status;

endmodule

`default_nettype wire

// ----- test/tb.sv -----
// Self-checking testbench for packbits_scanline_decoder_unit: directed table, random scanlines.
module tb;
  import pbsd_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;

  // Beat kinds on the input side
  localparam logic REQ_LEN  = 1'b0;
  localparam logic REQ_BYTE = 1'b1;

  // How a stimulus row is checked: by the predictor, by a value typed into it, or not at all
  typedef enum logic [1:0] {
    CHK_MODEL,
    CHK_SILENT,
    CHK_TYPED
  } chk_t;

  typedef struct {
    bit                     is_cfg;
    logic                   req;
    logic signed [15:0]     len;
    logic [7:0]             dbyte;
    logic [CFG_IDX_W-1:0]   idx;
    logic [LIMIT_W-1:0]     val;
    chk_t                   chk;
    run_rec_t               want;
  } plan_row_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_push = 1'b0;
  logic                   in_full;
  logic                   in_req_type = 1'b0;
  logic signed [15:0]     in_line_length = '0;
  logic [7:0]             in_data_byte = '0;
  logic                   out_empty;
  logic                   out_pop = 1'b0;
  logic [7:0]             out_run_value;
  logic [7:0]             out_run_count;
  logic [2:0]             out_status;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [LIMIT_W-1:0]     cfg_data = '0;

  // Mirror of the decoder: configuration and decode state, both at reset values
  logic [LIMIT_W-1:0]     lim = OUT_LIMIT_RST;
  logic [LINES_W-1:0]     lines_cap = SCANLINE_COUNT_RST;
  mode_t                  dec_mode = MODE_HEADER;
  logic [7:0]             lit_left = '0;
  logic [7:0]             rep_len = '0;
  logic [14:0]            line_left = '0;
  logic [LIMIT_W-1:0]     written = '0;
  logic [LINES_W-1:0]     lines_seen = '0;
  bit                     halted = 1'b0;

  run_rec_t               runs_due[$];
  plan_row_t              plan[$];
  int                     fails = 0;
  int                     beats_sent = 0;
  int                     burst_left = 0;
  int                     hold_req = 0;
  int                     cycles = 0;

  packbits_scanline_decoder_unit u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_req_type    (in_req_type),
    .in_line_length (in_line_length),
    .in_data_byte   (in_data_byte),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_run_value  (out_run_value),
    .out_run_count  (out_run_count),
    .out_status     (out_status),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Watchdog: a correct run ends far below this count
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("packbits_scanline_decoder_unit verification failed");
      $finish;
    end
  end

  function automatic run_rec_t rec(input logic [7:0] v, input logic [7:0] c, input status_t st);
    run_rec_t r;
    r.run_value = v;
    r.run_count = c;
    r.status    = st;
    return r;
  endfunction

  // Scanline cap as the decoder sees it: counts above the line limit saturate
  function automatic logic [LINES_W-1:0] lines_allowed();
    return (lines_cap > LINES_W'(MAX_LINES_DEF)) ? LINES_W'(MAX_LINES_DEF) : lines_cap;
  endfunction

  // Latch the sticky error and build its status record
  function automatic bit trip(input status_t st, output run_rec_t r);
    halted = 1'b1;
    r = rec(8'd0, 8'd0, st);
    return 1'b1;
  endfunction

  // Predict one accepted beat: advance the mirror, return 1 with the run it yields
  function automatic bit decode_beat(input logic req, input logic [15:0] len,
                                     input logic [7:0] db, output run_rec_t r);
    logic [7:0] cnt;
    r = rec(db, 8'd0, ST_RUN);
    if (halted)
      return 1'b0;
    if (req == REQ_LEN) begin
      if (line_left != 0 || lines_seen >= lines_allowed())
        return trip(ST_UNEXPECTED, r);
      if (len == 16'd0 || len[15])
        return trip(ST_BAD_LEN, r);
      line_left  = len[14:0];
      lines_seen = lines_seen + 1'b1;
      dec_mode   = MODE_HEADER;
      return 1'b0;
    end
    if (line_left == 0)
      return trip(ST_UNEXPECTED, r);
    line_left = line_left - 1'b1;
    if (dec_mode == MODE_LITERAL) begin
      if (lit_left != 0)
        lit_left = lit_left - 1'b1;
      if (lit_left == 0)
        dec_mode = MODE_HEADER;
      r.run_count = 8'd1;
      return 1'b1;
    end
    if (dec_mode == MODE_REPEAT) begin
      dec_mode    = MODE_HEADER;
      r.run_count = rep_len;
      rep_len     = 8'd0;
      return 1'b1;
    end
    // header byte
    if (db == HDR_NOP)
      return 1'b0;
    if (db < HDR_NOP) begin
      cnt = db + 8'd1;
      if (cnt > line_left)
        return trip(ST_PAST_LINE, r);
    end else begin
      cnt = 8'(9'd257 - {1'b0, db});
      if (line_left == 0)
        return trip(ST_PAST_LINE, r);
    end
    if ({1'b0, written} + cnt > {1'b0, lim})
      return trip(ST_OVERFLOW, r);
    written = written + cnt;
    if (db < HDR_NOP) begin
      dec_mode = MODE_LITERAL;
      lit_left = cnt;
    end else begin
      dec_mode = MODE_REPEAT;
      rep_len  = cnt;
    end
    return 1'b0;
  endfunction

  function automatic void add_beat(input logic req, input logic signed [15:0] len,
                                   input logic [7:0] db, input chk_t chk, input run_rec_t want);
    plan_row_t row;
    row = '{is_cfg: 1'b0, req: req, len: len, dbyte: db, idx: '0, val: '0,
            chk: chk, want: want};
    plan.push_back(row);
  endfunction

  function automatic void add_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [LIMIT_W-1:0] val);
    plan_row_t row;
    row = '{is_cfg: 1'b1, req: REQ_LEN, len: '0, dbyte: '0, idx: idx, val: val,
            chk: CHK_SILENT, want: '0};
    plan.push_back(row);
  endfunction

  // Offer one beat in the current burst; a used-up burst starts anew, maybe after a gap.
  // Entered and left at a falling edge, with in_push still high on the way out.
  task automatic push_beat(input logic req, input logic signed [15:0] len, input logic [7:0] db,
                           input chk_t chk, input run_rec_t want);
    run_rec_t r;
    bit       got;
    int       gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_push <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_push        <= 1'b1;
    in_req_type    <= req;
    in_line_length <= len;
    in_data_byte   <= db;
    do @(posedge clk); while (in_full);
    beats_sent++;
    got = decode_beat(req, len, db, r);
    // typed rows still advance the mirror, but check against the row's own value
    if (chk != CHK_MODEL) begin
      got = (chk == CHK_TYPED);
      r   = want;
    end
    if (got)
      runs_due.push_back(r);
    @(negedge clk);
  endtask

  // Drain: drop push, wait for every expected run, then idle before returning
  task automatic settle();
    in_push <= 1'b0;
    while (runs_due.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [LIMIT_W-1:0] val);
    settle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_OUT_LIMIT)
      lim = val;
    else
      lines_cap = val[LINES_W-1:0];
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_plan();
    foreach (plan[i]) begin
      if (plan[i].is_cfg)
        write_reg(plan[i].idx, plan[i].val);
      else
        push_beat(plan[i].req, plan[i].len, plan[i].dbyte, plan[i].chk, plan[i].want);
    end
    plan.delete();
  endtask

  // Build one well-formed scanline of random packets, sized to stay inside the output limit,
  // then send its length beat and its bytes.
  task automatic send_scanline();
    logic [7:0]  line_q[$];
    logic [29:0] room;
    logic [7:0]  hdr;
    int          npk;
    int          pick;
    int          n;
    room = (lim > written) ? {1'b0, lim} - {1'b0, written} : 30'd0;
    npk  = ($urandom_range(0, 15) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 5);
    repeat (npk) begin
      pick = (room == 0) ? 0 : $urandom_range(0, 9);
      if (pick == 0) begin
        line_q.push_back(HDR_NOP);
      end else if (pick < 5 || room < 2) begin
        n = ($urandom_range(0, 15) == 0) ? 127 : $urandom_range(0, 7);
        if (n + 1 > room)
          n = room - 1;
        line_q.push_back(8'(n));
        repeat (n + 1) line_q.push_back(8'($urandom_range(0, 255)));
        room = room - (n + 1);
      end else begin
        case ($urandom_range(0, 7))
          0: hdr = 8'd129;
          1: hdr = 8'd255;
          default: hdr = 8'($urandom_range(129, 255));
        endcase
        if (257 - hdr > room)
          hdr = 8'(257 - room);
        line_q.push_back(hdr);
        line_q.push_back(8'($urandom_range(0, 255)));
        room = room - (257 - hdr);
      end
    end
    // the length field is ignored on byte beats, so fill it with noise there
    push_beat(REQ_LEN, 16'(line_q.size()), 8'($urandom_range(0, 255)), CHK_MODEL, '0);
    foreach (line_q[i])
      push_beat(REQ_BYTE, 16'($urandom_range(0, 65535)), line_q[i], CHK_MODEL, '0);
  endtask

  // Result side: stall on a mode pattern, honor long hold-offs, and check every popped run
  initial begin
    run_rec_t want;
    int       mode;
    int       mode_left;
    int       hold_left;
    int       tick;
    mode      = 0;
    mode_left = 0;
    hold_left = 0;
    tick      = 0;
    forever begin
      @(posedge clk);
      if (hold_req != 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (out_pop && !out_empty) begin
        if (runs_due.size() == 0) begin
          fails++;
          $display("%0t: run beat with none expected: value %0d count %0d status %0d",
                   $time, out_run_value, out_run_count, out_status);
        end else begin
          want = runs_due.pop_front();
          if (out_run_value !== want.run_value) begin
            fails++;
            $display("%0t: run_value expected %0d actual %0d",
                     $time, want.run_value, out_run_value);
          end
          if (out_run_count !== want.run_count) begin
            fails++;
            $display("%0t: run_count expected %0d actual %0d",
                     $time, want.run_count, out_run_count);
          end
          if (out_status !== want.status) begin
            fails++;
            $display("%0t: status expected %0d actual %0d", $time, want.status, out_status);
          end
        end
      end
      @(negedge clk);
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 3);
        mode_left = $urandom_range(16, 96);
      end
      mode_left--;
      tick++;
      if (hold_left != 0) begin
        // hold off entirely so the result queue fills and in_full rises
        hold_left--;
        out_pop <= 1'b0;
      end else begin
        case (mode)
          0: out_pop <= 1'b1;
          1: out_pop <= 1'($urandom_range(0, 1));
          2: out_pop <= (tick % 4 == 0);
          default: out_pop <= ($urandom_range(0, 7) == 0);
        endcase
      end
    end
  end

  // Stimulus: directed table, four random phases under different limits, one error ending
  initial begin
    logic signed [15:0] neg_len;
    int                 ph;
    int                 goal;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset limits are one byte and one line: a single one-byte literal fills both
    add_beat(REQ_LEN, 16'sd2, 8'($urandom), CHK_SILENT, '0);
    add_beat(REQ_BYTE, 16'($urandom), 8'd0, CHK_SILENT, '0);
    add_beat(REQ_BYTE, 16'($urandom), 8'hAB, CHK_TYPED, rec(8'hAB, 8'd1, ST_RUN));
    // open the limits wide; the scanline register keeps only its low bits
    add_cfg(REG_OUT_LIMIT, 29'h1FFF_FFFF);
    add_cfg(REG_SCANLINE_COUNT, 29'h1FFF_FFFF);
    add_beat(REQ_LEN, 16'sd8, 8'($urandom), CHK_SILENT, '0);
    add_beat(REQ_BYTE, 16'($urandom), HDR_NOP, CHK_SILENT, '0);
    add_beat(REQ_BYTE, 16'($urandom), 8'd129, CHK_SILENT, '0);
    add_beat(REQ_BYTE, 16'($urandom), 8'hFF, CHK_TYPED, rec(8'hFF, 8'd128, ST_RUN));
    add_beat(REQ_BYTE, 16'($urandom), 8'd255, CHK_SILENT, '0);
    add_beat(REQ_BYTE, 16'($urandom), 8'h00, CHK_TYPED, rec(8'h00, 8'd2, ST_RUN));
    add_beat(REQ_BYTE, 16'($urandom), 8'd1, CHK_SILENT, '0);
    add_beat(REQ_BYTE, 16'($urandom), 8'h55, CHK_TYPED, rec(8'h55, 8'd1, ST_RUN));
    add_beat(REQ_BYTE, 16'($urandom), 8'hAA, CHK_TYPED, rec(8'hAA, 8'd1, ST_RUN));
    // a repeat of 127 and a trailing no-op header, left to the predictor
    add_beat(REQ_LEN, 16'sd3, 8'($urandom), CHK_MODEL, '0);
    add_beat(REQ_BYTE, 16'($urandom), 8'd130, CHK_MODEL, '0);
    add_beat(REQ_BYTE, 16'($urandom), 8'h5A, CHK_MODEL, '0);
    add_beat(REQ_BYTE, 16'($urandom), HDR_NOP, CHK_MODEL, '0);
    run_plan();

    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          write_reg(REG_OUT_LIMIT, 29'h1FFF_FFFF);
          write_reg(REG_SCANLINE_COUNT, 29'd16385);
        end
        1: begin
          write_reg(REG_OUT_LIMIT, 29'd268435456);
          write_reg(REG_SCANLINE_COUNT, 29'd16384);
        end
        2: begin
          // tight byte budget: ends when the output limit is used up or the beat goal is met
          write_reg(REG_OUT_LIMIT, written + 29'($urandom_range(300, 3000)));
          write_reg(REG_SCANLINE_COUNT, 29'(lines_seen) + 29'd400);
        end
        default: begin
          // tight line budget: ends on the last allowed scanline or when the beat goal is met
          write_reg(REG_OUT_LIMIT, 29'h1FFF_FFFF);
          write_reg(REG_SCANLINE_COUNT, 29'(lines_seen) + 29'($urandom_range(30, 60)));
        end
      endcase
      hold_req = 200;
      goal = beats_sent + 490;
      while (beats_sent < goal && lines_seen < lines_allowed() && lim > written)
        send_scanline();
    end

    // Error ending: one failure per run, since only reset clears the sticky error
    add_cfg(REG_SCANLINE_COUNT, 29'd16384);
    add_cfg(REG_OUT_LIMIT, 29'h1FFF_FFFF);
    case ($urandom_range(0, 7))
      0: add_beat(REQ_LEN, 16'sd0, 8'($urandom), CHK_TYPED, rec(8'd0, 8'd0, ST_BAD_LEN));
      1: begin
        neg_len = ($urandom_range(0, 1) == 0) ? 16'sh8000 : 16'(0 - $urandom_range(1, 32767));
        add_beat(REQ_LEN, neg_len, 8'($urandom), CHK_TYPED, rec(8'd0, 8'd0, ST_BAD_LEN));
      end
      2: begin
        // literal longer than the rest of the line
        add_beat(REQ_LEN, 16'sd3, 8'($urandom), CHK_SILENT, '0);
        add_beat(REQ_BYTE, 16'($urandom), 8'($urandom_range(2, 127)), CHK_TYPED,
                 rec(8'd0, 8'd0, ST_PAST_LINE));
      end
      3: begin
        // repeat header as the last byte of its line
        add_beat(REQ_LEN, 16'sd1, 8'($urandom), CHK_SILENT, '0);
        add_beat(REQ_BYTE, 16'($urandom), 8'($urandom_range(129, 255)), CHK_TYPED,
                 rec(8'd0, 8'd0, ST_PAST_LINE));
      end
      4: begin
        add_cfg(REG_OUT_LIMIT, ($urandom_range(0, 1) == 0) ? 29'd0 : written);
        add_beat(REQ_LEN, 16'sd8, 8'($urandom), CHK_SILENT, '0);
        add_beat(REQ_BYTE, 16'($urandom), 8'($urandom_range(0, 3)), CHK_TYPED,
                 rec(8'd0, 8'd0, ST_OVERFLOW));
      end
      5: begin
        // length beat while the current line still has bytes
        add_beat(REQ_LEN, 16'sd5, 8'($urandom), CHK_SILENT, '0);
        add_beat(REQ_BYTE, 16'($urandom), 8'd0, CHK_SILENT, '0);
        add_beat(REQ_BYTE, 16'($urandom), 8'($urandom), CHK_MODEL, '0);
        add_beat(REQ_LEN, 16'sd3, 8'($urandom), CHK_TYPED, rec(8'd0, 8'd0, ST_UNEXPECTED));
      end
      6: begin
        // no scanlines left, including a count of zero
        add_cfg(REG_SCANLINE_COUNT,
                ($urandom_range(0, 1) == 0) ? 29'd0 : 29'(lines_seen));
        add_beat(REQ_LEN, 16'sd2, 8'($urandom), CHK_TYPED, rec(8'd0, 8'd0, ST_UNEXPECTED));
      end
      default: begin
        // data byte with no open line
        add_beat(REQ_BYTE, 16'($urandom), 8'($urandom), CHK_TYPED,
                 rec(8'd0, 8'd0, ST_UNEXPECTED));
      end
    endcase
    // a register write must not clear the error; everything after stays silent
    add_cfg(REG_OUT_LIMIT, 29'h1FFF_FFFF);
    repeat (12)
      add_beat(1'($urandom_range(0, 1)), 16'($urandom), 8'($urandom), CHK_SILENT, '0);
    run_plan();

    settle();
    repeat (8) @(negedge clk);
    if (fails == 0)
      $display("packbits_scanline_decoder_unit verification clean");
    else
      $display("packbits_scanline_decoder_unit verification failed");
    $finish;
  end

endmodule
